// ===== design/h264sps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264sps_pkg
// Shared types, codes and tables for the H.264 SPS field extractor.
// ----------------------------------------------------------------------------
package h264sps_pkg;

  localparam int DIV_BITS = 49;                 // width of 90000 * ticks
  localparam int DIV_CNT_W = $clog2(DIV_BITS);
  localparam logic [16:0] TICKS_90K = 17'd90000;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_PROF  = 2'd1;
  localparam logic [1:0] ST_BAD_POC   = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  localparam logic [7:0] ASPECT_EXT = 8'd255;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pic_width;
    logic [15:0] pic_height;
    logic [15:0] sar_num;
    logic [15:0] sar_den;
    logic        timing_valid;
    logic [31:0] tick_units;
    logic [31:0] time_scale_out;
    logic [31:0] frame_duration;
  } out_t;

  typedef enum logic [5:0] {
    PH_IDLE, PH_PROFILE, PH_CONSTR, PH_LEVEL, PH_SPSID, PH_CHROMA, PH_RESID,
    PH_BDL, PH_BDC, PH_BYPASS, PH_SMPRES, PH_LISTFLAG, PH_DELTA, PH_LOG2FN,
    PH_POCTYPE, PH_POCLSB, PH_DPOAZ, PH_OFFNR, PH_OFFTB, PH_NCYCLE, PH_OFFREF,
    PH_REFS, PH_GAPS, PH_WMB, PH_HMB, PH_FMO, PH_MBAFF, PH_D8, PH_CROPF,
    PH_CL, PH_CR, PH_CT, PH_CB, PH_VUI, PH_ARPRES, PH_ARIDC, PH_SARW, PH_SARH,
    PH_OVS, PH_OVSAPP, PH_VST, PH_VFMT, PH_COLP, PH_COLD, PH_CHL, PH_CHT,
    PH_CHB, PH_TIM, PH_NUT, PH_TS, PH_FIXED, PH_END
  } phase_t;

  typedef enum logic [1:0] {RD_FIXED, RD_PREFIX, RD_SUFFIX} rd_mode_t;

  typedef enum logic [2:0] {
    C_IDLE, C_BITS, C_FIN, C_MUL, C_DIV, C_DEND, C_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic bit_step;
    logic fin;
    logic mul;
    logic div_step;
    logic div_end;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic result_ready;
    logic div_pending;
  } stat_t;

  function automatic logic [31:0] sar_lookup(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd1:    r = {16'd1,   16'd1};
      5'd2:    r = {16'd12,  16'd11};
      5'd3:    r = {16'd10,  16'd11};
      5'd4:    r = {16'd16,  16'd11};
      5'd5:    r = {16'd40,  16'd33};
      5'd6:    r = {16'd24,  16'd11};
      5'd7:    r = {16'd20,  16'd11};
      5'd8:    r = {16'd32,  16'd11};
      5'd9:    r = {16'd80,  16'd33};
      5'd10:   r = {16'd18,  16'd11};
      5'd11:   r = {16'd15,  16'd11};
      5'd12:   r = {16'd64,  16'd33};
      5'd13:   r = {16'd160, 16'd99};
      5'd14:   r = {16'd4,   16'd3};
      5'd15:   r = {16'd3,   16'd2};
      5'd16:   r = {16'd2,   16'd1};
      default: r = {16'd0,   16'd1};
    endcase
    return r;
  endfunction

endpackage

// ===== design/h264sps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264sps_ctrl
// Sequencer: byte load, eight bit steps, wrap-up, duration divide, emit.
// ----------------------------------------------------------------------------
module h264sps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  h264sps_pkg::stat_t  stat,
  output h264sps_pkg::cmd_t   cmd
);

  h264sps_pkg::ctrl_state_t state, state_next;
  logic [2:0] bit_cnt, bit_cnt_next;
  logic [h264sps_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= h264sps_pkg::C_IDLE;
      bit_cnt   <= '0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      bit_cnt   <= bit_cnt_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    bit_cnt_next   = bit_cnt;
    div_cnt_next   = div_cnt;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state)
      h264sps_pkg::C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          bit_cnt_next = '0;
          state_next   = h264sps_pkg::C_BITS;
        end
      end
      h264sps_pkg::C_BITS: begin
        cmd.bit_step = 1'b1;
        bit_cnt_next = bit_cnt + 3'd1;
        if (bit_cnt == 3'd7) state_next = h264sps_pkg::C_FIN;
      end
      h264sps_pkg::C_FIN: begin
        cmd.fin = 1'b1;
        priority if (stat.div_pending) state_next = h264sps_pkg::C_MUL;
        else if (stat.result_ready || (1'b0)) state_next = h264sps_pkg::C_EMIT;
        else state_next = h264sps_pkg::C_IDLE;
      end
      h264sps_pkg::C_MUL: begin
        cmd.mul      = 1'b1;
        div_cnt_next = '0;
        state_next   = h264sps_pkg::C_DIV;
      end
      h264sps_pkg::C_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == h264sps_pkg::DIV_CNT_W'(h264sps_pkg::DIV_BITS - 1))
          state_next = h264sps_pkg::C_DEND;
      end
      h264sps_pkg::C_DEND: begin
        cmd.div_end = 1'b1;
        state_next  = h264sps_pkg::C_EMIT;
      end
      h264sps_pkg::C_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = h264sps_pkg::C_IDLE;
        end
      end
      default: state_next = h264sps_pkg::C_IDLE;
    endcase
  end

endmodule

// ===== design/h264sps_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264sps_dp
// Bit-serial SPS parser datapath, duration divider and result register.
// ----------------------------------------------------------------------------
module h264sps_dp (
  input  logic                clk,
  input  logic                rst,
  input  h264sps_pkg::in_t    in_data,
  input  h264sps_pkg::cmd_t   cmd,
  output h264sps_pkg::stat_t  stat,
  output h264sps_pkg::out_t   out_data
);

  h264sps_pkg::phase_t   phase, phase_next;
  h264sps_pkg::rd_mode_t mode, mode_next;
  logic [5:0]  zc, zc_next, fbl, fbl_next;
  logic [31:0] gv, gv_next, loop_cnt, loop_cnt_next;
  logic [7:0]  profile, profile_next, sh, sh_next;
  logic [3:0]  list_idx, list_idx_next;
  logic [15:0] sln, sln_next;
  logic signed [39:0] wacc, wacc_next, hacc, hacc_next;
  logic        fmf, fmf_next, last_q, last_q_next;
  logic [31:0] sar, sar_next, held, held_next;
  logic [31:0] k_tick, k_tick_next, k_ts, k_ts_next, k_dur, k_dur_next;
  logic [1:0]  st, st_next;
  logic        timing, timing_next, rr, rr_next, dpend, dpend_next;
  logic [h264sps_pkg::DIV_BITS-1:0] dvd, dvd_next, quo, quo_next;
  logic [32:0] rem, rem_next;
  logic        trunc_now;

  // scratch for the field decode
  logic        b, got_en, w_en, f_en;
  logic [31:0] got_v;
  h264sps_pkg::phase_t w_ph;
  logic [5:0]  w_n;
  logic [1:0]  f_st;
  logic [32:0] v33, mag, r1;
  logic [7:0]  s8, nxt8, last8;
  logic [31:0] loop_inc;
  logic [3:0]  li_inc;
  logic [6:0]  lsize;

  function automatic logic [15:0] clamp16(input logic signed [39:0] v);
    if (v < 0) return 16'd0;
    if (v > 40'sd65535) return 16'hffff;
    return v[15:0];
  endfunction

  function automatic logic is_high(input logic [7:0] p);
    return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 || p == 8'd44;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= h264sps_pkg::PH_IDLE;
      mode <= h264sps_pkg::RD_FIXED;
      zc <= '0; fbl <= '0; gv <= '0; loop_cnt <= '0;
      profile <= '0; list_idx <= '0; sln <= 16'h0808;
      wacc <= '0; hacc <= '0; fmf <= 1'b0; sar <= 32'd1; held <= '0;
      k_tick <= '0; k_ts <= '0; k_dur <= '0;
      st <= '0; timing <= 1'b0; rr <= 1'b0; dpend <= 1'b0; last_q <= 1'b0;
    end else begin
      phase <= phase_next; mode <= mode_next;
      zc <= zc_next; fbl <= fbl_next; gv <= gv_next; loop_cnt <= loop_cnt_next;
      profile <= profile_next; list_idx <= list_idx_next; sln <= sln_next;
      wacc <= wacc_next; hacc <= hacc_next; fmf <= fmf_next; sar <= sar_next;
      held <= held_next; k_tick <= k_tick_next; k_ts <= k_ts_next;
      k_dur <= k_dur_next; st <= st_next; timing <= timing_next; rr <= rr_next;
      dpend <= dpend_next; last_q <= last_q_next;
    end
  end

  always_ff @(posedge clk) begin
    sh  <= sh_next;
    dvd <= dvd_next;
    quo <= quo_next;
    rem <= rem_next;
    if (cmd.emit) begin
      if (st == h264sps_pkg::ST_OK) begin
        out_data.pic_width    <= clamp16(wacc);
        out_data.pic_height   <= clamp16(hacc);
        out_data.sar_num      <= sar[31:16];
        out_data.sar_den      <= sar[15:0];
        out_data.timing_valid <= timing;
      end else begin
        out_data.pic_width    <= '0;
        out_data.pic_height   <= '0;
        out_data.sar_num      <= '0;
        out_data.sar_den      <= 16'd1;
        out_data.timing_valid <= 1'b0;
      end
      out_data.status         <= st;
      out_data.tick_units     <= k_tick;
      out_data.time_scale_out <= k_ts;
      out_data.frame_duration <= k_dur;
    end
  end

  // a payload that ends mid-parse reports in the wrap-up cycle itself
  assign trunc_now = cmd.fin && last_q && phase != h264sps_pkg::PH_IDLE &&
                     phase != h264sps_pkg::PH_END;

  assign stat.result_ready = rr || trunc_now;
  assign stat.div_pending  = dpend;

  always_comb begin
    phase_next = phase; mode_next = mode; zc_next = zc; fbl_next = fbl;
    gv_next = gv; loop_cnt_next = loop_cnt; profile_next = profile;
    list_idx_next = list_idx; sln_next = sln; wacc_next = wacc;
    hacc_next = hacc; fmf_next = fmf; sar_next = sar; held_next = held;
    k_tick_next = k_tick; k_ts_next = k_ts; k_dur_next = k_dur;
    st_next = st; timing_next = timing; rr_next = rr; dpend_next = dpend;
    last_q_next = last_q; sh_next = sh;
    dvd_next = dvd; quo_next = quo; rem_next = rem;
    b = sh[7]; got_en = 1'b0; got_v = '0;
    w_en = 1'b0; w_ph = h264sps_pkg::PH_IDLE; w_n = '0;
    f_en = 1'b0; f_st = h264sps_pkg::ST_OK;
    v33 = '0; mag = '0; s8 = '0; nxt8 = '0; last8 = '0; r1 = '0;
    loop_inc = loop_cnt + 32'd1;
    li_inc = list_idx + 4'd1;
    lsize = (list_idx < 4'd6) ? 7'd16 : 7'd64;

    if (cmd.load) begin
      sh_next = in_data.data_byte;
      last_q_next = in_data.last_byte;
      rr_next = 1'b0;
      dpend_next = 1'b0;
      if (in_data.first_byte) begin
        phase_next = h264sps_pkg::PH_PROFILE;
        mode_next = h264sps_pkg::RD_FIXED;
        zc_next = '0; gv_next = '0; fbl_next = 6'd8;
        profile_next = '0; loop_cnt_next = '0; list_idx_next = '0;
        sln_next = 16'h0808; wacc_next = '0; hacc_next = '0; fmf_next = 1'b0;
        sar_next = 32'd1; held_next = '0; st_next = h264sps_pkg::ST_OK;
        timing_next = 1'b0;
      end
    end else if (cmd.bit_step) begin
      sh_next = {sh[6:0], 1'b0};
      if (phase != h264sps_pkg::PH_IDLE && phase != h264sps_pkg::PH_END) begin
        case (mode)
          h264sps_pkg::RD_PREFIX: begin
            if (!b) begin
              if (zc < 6'd63) zc_next = zc + 6'd1;
            end else if (zc == 6'd0) begin
              got_en = 1'b1;
            end else begin
              gv_next = 32'd1;
              fbl_next = zc;
              mode_next = h264sps_pkg::RD_SUFFIX;
            end
          end
          h264sps_pkg::RD_SUFFIX: begin
            gv_next = {gv[30:0], b};
            fbl_next = fbl - 6'd1;
            if (fbl == 6'd1) begin
              got_en = 1'b1;
              got_v = gv_next - 32'd1;
            end
          end
          default: begin
            gv_next = {gv[30:0], b};
            fbl_next = fbl - 6'd1;
            if (fbl == 6'd1) begin
              got_en = 1'b1;
              got_v = gv_next;
            end
          end
        endcase
      end

      if (got_en) begin
        v33 = {1'b0, got_v} + 33'd1;
        unique case (phase)
          h264sps_pkg::PH_PROFILE: begin
            profile_next = got_v[7:0];
            if (got_v == 32'd66 || got_v == 32'd77 || got_v == 32'd88 ||
                is_high(got_v[7:0])) begin
              w_en = 1'b1; w_ph = h264sps_pkg::PH_CONSTR; w_n = 6'd8;
            end else begin
              f_en = 1'b1; f_st = h264sps_pkg::ST_BAD_PROF;
            end
          end
          h264sps_pkg::PH_CONSTR: begin
            w_en = 1'b1; w_ph = h264sps_pkg::PH_LEVEL; w_n = 6'd8;
          end
          h264sps_pkg::PH_LEVEL: begin
            w_en = 1'b1; w_ph = h264sps_pkg::PH_SPSID;
          end
          h264sps_pkg::PH_SPSID: begin
            w_en = 1'b1;
            w_ph = is_high(profile) ? h264sps_pkg::PH_CHROMA : h264sps_pkg::PH_LOG2FN;
          end
          h264sps_pkg::PH_CHROMA: begin
            w_en = 1'b1;
            if (got_v == 32'd3) begin
              w_ph = h264sps_pkg::PH_RESID; w_n = 6'd1;
            end else w_ph = h264sps_pkg::PH_BDL;
          end
          h264sps_pkg::PH_RESID: begin w_en = 1'b1; w_ph = h264sps_pkg::PH_BDL; end
          h264sps_pkg::PH_BDL:   begin w_en = 1'b1; w_ph = h264sps_pkg::PH_BDC; end
          h264sps_pkg::PH_BDC: begin
            w_en = 1'b1; w_ph = h264sps_pkg::PH_BYPASS; w_n = 6'd1;
          end
          h264sps_pkg::PH_BYPASS: begin
            w_en = 1'b1; w_ph = h264sps_pkg::PH_SMPRES; w_n = 6'd1;
          end
          h264sps_pkg::PH_SMPRES: begin
            w_en = 1'b1;
            if (got_v != 0) begin
              list_idx_next = '0; w_ph = h264sps_pkg::PH_LISTFLAG; w_n = 6'd1;
            end else w_ph = h264sps_pkg::PH_LOG2FN;
          end
          h264sps_pkg::PH_LISTFLAG: begin
            w_en = 1'b1;
            if (got_v != 0) begin
              // next scale starts at 8, so the first delta is always read
              loop_cnt_next = '0; sln_next = 16'h0808; w_ph = h264sps_pkg::PH_DELTA;
            end else begin
              list_idx_next = li_inc;
              if (li_inc < 4'd8) begin
                w_ph = h264sps_pkg::PH_LISTFLAG; w_n = 6'd1;
              end else w_ph = h264sps_pkg::PH_LOG2FN;
            end
          end
          h264sps_pkg::PH_DELTA: begin
            mag = v33 >> 1;
            s8 = got_v[0] ? mag[7:0] : (8'd0 - mag[7:0]);
            last8 = sln[15:8];
            nxt8 = last8 + s8;
            if (nxt8 != 8'd0) last8 = nxt8;
            sln_next = {last8, nxt8};
            loop_cnt_next = loop_inc;
            w_en = 1'b1;
            // a zero next scale repeats the last one to the end of the list
            if (nxt8 != 8'd0 && loop_inc < {25'd0, lsize}) begin
              w_ph = h264sps_pkg::PH_DELTA;
            end else begin
              list_idx_next = li_inc;
              if (li_inc < 4'd8) begin
                w_ph = h264sps_pkg::PH_LISTFLAG; w_n = 6'd1;
              end else w_ph = h264sps_pkg::PH_LOG2FN;
            end
          end
          h264sps_pkg::PH_LOG2FN: begin w_en = 1'b1; w_ph = h264sps_pkg::PH_POCTYPE; end
          h264sps_pkg::PH_POCTYPE: begin
            priority if (got_v == 32'd0) begin
              w_en = 1'b1; w_ph = h264sps_pkg::PH_POCLSB;
            end else if (got_v == 32'd1) begin
              w_en = 1'b1; w_ph = h264sps_pkg::PH_DPOAZ; w_n = 6'd1;
            end else if (got_v == 32'd2) begin
              w_en = 1'b1; w_ph = h264sps_pkg::PH_REFS;
            end else begin
              f_en = 1'b1; f_st = h264sps_pkg::ST_BAD_POC;
            end
          end
          h264sps_pkg::PH_POCLSB: begin w_en = 1'b1; w_ph = h264sps_pkg::PH_REFS; end
          h264sps_pkg::PH_DPOAZ:  begin w_en = 1'b1; w_ph = h264sps_pkg::PH_OFFNR; end
          h264sps_pkg::PH_OFFNR:  begin w_en = 1'b1; w_ph = h264sps_pkg::PH_OFFTB; end
          h264sps_pkg::PH_OFFTB:  begin w_en = 1'b1; w_ph = h264sps_pkg::PH_NCYCLE; end
          h264sps_pkg::PH_NCYCLE: begin
            loop_cnt_next = got_v; w_en = 1'b1;
            w_ph = (got_v != 0) ? h264sps_pkg::PH_OFFREF : h264sps_pkg::PH_REFS;
          end
          h264sps_pkg::PH_OFFREF: begin
            loop_cnt_next = loop_cnt - 32'd1; w_en = 1'b1;
            w_ph = (loop_cnt_next != 0) ? h264sps_pkg::PH_OFFREF : h264sps_pkg::PH_REFS;
          end
          h264sps_pkg::PH_REFS: begin
            w_en = 1'b1; w_ph = h264sps_pkg::PH_GAPS; w_n = 6'd1;
          end
          h264sps_pkg::PH_GAPS: begin w_en = 1'b1; w_ph = h264sps_pkg::PH_WMB; end
          h264sps_pkg::PH_WMB: begin
            wacc_next = {3'd0, v33, 4'd0};
            w_en = 1'b1; w_ph = h264sps_pkg::PH_HMB;
          end
          h264sps_pkg::PH_HMB: begin
            hacc_next = {7'd0, v33};
            w_en = 1'b1; w_ph = h264sps_pkg::PH_FMO; w_n = 6'd1;
          end
          h264sps_pkg::PH_FMO: begin
            fmf_next = got_v[0];
            hacc_next = got_v[0] ? (hacc <<< 4) : (hacc <<< 5);
            w_en = 1'b1; w_n = 6'd1;
            w_ph = got_v[0] ? h264sps_pkg::PH_D8 : h264sps_pkg::PH_MBAFF;
          end
          h264sps_pkg::PH_MBAFF: begin
            w_en = 1'b1; w_ph = h264sps_pkg::PH_D8; w_n = 6'd1;
          end
          h264sps_pkg::PH_D8: begin
            w_en = 1'b1; w_ph = h264sps_pkg::PH_CROPF; w_n = 6'd1;
          end
          h264sps_pkg::PH_CROPF: begin
            w_en = 1'b1;
            if (got_v != 0) w_ph = h264sps_pkg::PH_CL;
            else begin
              w_ph = h264sps_pkg::PH_VUI; w_n = 6'd1;
            end
          end
          h264sps_pkg::PH_CL: begin
            wacc_next = wacc - $signed({7'd0, got_v, 1'b0});
            w_en = 1'b1; w_ph = h264sps_pkg::PH_CR;
          end
          h264sps_pkg::PH_CR: begin
            wacc_next = wacc - $signed({7'd0, got_v, 1'b0});
            w_en = 1'b1; w_ph = h264sps_pkg::PH_CT;
          end
          h264sps_pkg::PH_CT: begin
            hacc_next = hacc - (fmf ? $signed({7'd0, got_v, 1'b0})
                                    : $signed({6'd0, got_v, 2'b0}));
            w_en = 1'b1; w_ph = h264sps_pkg::PH_CB;
          end
          h264sps_pkg::PH_CB: begin
            hacc_next = hacc - (fmf ? $signed({7'd0, got_v, 1'b0})
                                    : $signed({6'd0, got_v, 2'b0}));
            w_en = 1'b1; w_ph = h264sps_pkg::PH_VUI; w_n = 6'd1;
          end
          h264sps_pkg::PH_VUI: begin
            if (got_v != 0) begin
              w_en = 1'b1; w_ph = h264sps_pkg::PH_ARPRES; w_n = 6'd1;
            end else f_en = 1'b1;
          end
          h264sps_pkg::PH_ARPRES: begin
            w_en = 1'b1;
            if (got_v != 0) begin
              w_ph = h264sps_pkg::PH_ARIDC; w_n = 6'd8;
            end else begin
              w_ph = h264sps_pkg::PH_OVS; w_n = 6'd1;
            end
          end
          h264sps_pkg::PH_ARIDC: begin
            w_en = 1'b1;
            if (got_v[7:0] == h264sps_pkg::ASPECT_EXT) begin
              w_ph = h264sps_pkg::PH_SARW; w_n = 6'd16;
            end else begin
              if (got_v[7:0] < 8'd17) sar_next = h264sps_pkg::sar_lookup(got_v[4:0]);
              w_ph = h264sps_pkg::PH_OVS; w_n = 6'd1;
            end
          end
          h264sps_pkg::PH_SARW: begin
            sar_next = {got_v[15:0], sar[15:0]};
            w_en = 1'b1; w_ph = h264sps_pkg::PH_SARH; w_n = 6'd16;
          end
          h264sps_pkg::PH_SARH: begin
            sar_next = {sar[31:16], got_v[15:0]};
            w_en = 1'b1; w_ph = h264sps_pkg::PH_OVS; w_n = 6'd1;
          end
          h264sps_pkg::PH_OVS: begin
            w_en = 1'b1; w_n = 6'd1;
            w_ph = (got_v != 0) ? h264sps_pkg::PH_OVSAPP : h264sps_pkg::PH_VST;
          end
          h264sps_pkg::PH_OVSAPP: begin
            w_en = 1'b1; w_ph = h264sps_pkg::PH_VST; w_n = 6'd1;
          end
          h264sps_pkg::PH_VST: begin
            w_en = 1'b1;
            if (got_v != 0) begin
              w_ph = h264sps_pkg::PH_VFMT; w_n = 6'd4;
            end else begin
              w_ph = h264sps_pkg::PH_CHL; w_n = 6'd1;
            end
          end
          h264sps_pkg::PH_VFMT: begin
            w_en = 1'b1; w_ph = h264sps_pkg::PH_COLP; w_n = 6'd1;
          end
          h264sps_pkg::PH_COLP: begin
            w_en = 1'b1;
            if (got_v != 0) begin
              w_ph = h264sps_pkg::PH_COLD; w_n = 6'd24;
            end else begin
              w_ph = h264sps_pkg::PH_CHL; w_n = 6'd1;
            end
          end
          h264sps_pkg::PH_COLD: begin
            w_en = 1'b1; w_ph = h264sps_pkg::PH_CHL; w_n = 6'd1;
          end
          h264sps_pkg::PH_CHL: begin
            w_en = 1'b1;
            if (got_v != 0) w_ph = h264sps_pkg::PH_CHT;
            else begin
              w_ph = h264sps_pkg::PH_TIM; w_n = 6'd1;
            end
          end
          h264sps_pkg::PH_CHT: begin w_en = 1'b1; w_ph = h264sps_pkg::PH_CHB; end
          h264sps_pkg::PH_CHB: begin
            w_en = 1'b1; w_ph = h264sps_pkg::PH_TIM; w_n = 6'd1;
          end
          h264sps_pkg::PH_TIM: begin
            if (got_v != 0) begin
              w_en = 1'b1; w_ph = h264sps_pkg::PH_NUT; w_n = 6'd32;
            end else f_en = 1'b1;
          end
          h264sps_pkg::PH_NUT: begin
            loop_cnt_next = got_v;
            w_en = 1'b1; w_ph = h264sps_pkg::PH_TS; w_n = 6'd32;
          end
          h264sps_pkg::PH_TS: begin
            held_next = got_v;
            w_en = 1'b1; w_ph = h264sps_pkg::PH_FIXED; w_n = 6'd1;
          end
          h264sps_pkg::PH_FIXED: begin
            if (got_v != 0) begin
              k_tick_next = {loop_cnt[30:0], 1'b0};
              k_ts_next = held;
              timing_next = 1'b1;
              dpend_next = 1'b1;
            end
            f_en = 1'b1;
          end
          default: ;
        endcase

        if (w_en) begin
          phase_next = w_ph;
          zc_next = '0;
          gv_next = '0;
          fbl_next = w_n;
          mode_next = (w_n != 6'd0) ? h264sps_pkg::RD_FIXED : h264sps_pkg::RD_PREFIX;
        end
        if (f_en) begin
          phase_next = h264sps_pkg::PH_END;
          st_next = f_st;
          rr_next = 1'b1;
        end
      end
    end else if (cmd.fin) begin
      if (last_q) begin
        if (trunc_now) begin
          st_next = h264sps_pkg::ST_TRUNC;
          rr_next = 1'b1;
        end
        phase_next = h264sps_pkg::PH_IDLE;
      end
    end else if (cmd.mul) begin
      dvd_next = {17'd0, k_tick} * h264sps_pkg::TICKS_90K;
      quo_next = '0;
      rem_next = '0;
    end else if (cmd.div_step) begin
      // restoring divide, one quotient bit per cycle
      r1 = {rem[31:0], dvd[h264sps_pkg::DIV_BITS-1]};
      dvd_next = {dvd[h264sps_pkg::DIV_BITS-2:0], 1'b0};
      if (r1 >= {1'b0, k_ts}) begin
        rem_next = r1 - {1'b0, k_ts};
        quo_next = {quo[h264sps_pkg::DIV_BITS-2:0], 1'b1};
      end else begin
        rem_next = r1;
        quo_next = {quo[h264sps_pkg::DIV_BITS-2:0], 1'b0};
      end
    end else if (cmd.div_end) begin
      priority if (k_ts == 32'd0) k_dur_next = '0;
      else if (quo[h264sps_pkg::DIV_BITS-1:32] != '0) k_dur_next = 32'hffff_ffff;
      else k_dur_next = quo[31:0];
    end
  end

endmodule

// ===== design/h264_sps_field_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_sps_field_extractor
// Bit-serial Exp-Golomb parser for H.264 SPS RBSP bytes; at most one result per set.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    in_data  (h264sps_pkg::in_t), one byte
//  output    out_valid / out_ready  out_data (h264sps_pkg::out_t), one result
//
//  A byte passes through accept, 8 bit steps in the field decoder and wrap-up.
//  A result adds an emit state; a set with fixed frame rate timing first computes
//  the 90 kHz duration (one multiply, 49-step restoring divider).
//  Reset returns the parser to idle and clears the kept timing values.
//  A waiting result does not block the next byte unless a new result is due.
// ----------------------------------------------------------------------------
module h264_sps_field_extractor (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  h264sps_pkg::in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output h264sps_pkg::out_t  out_data
);

  h264sps_pkg::cmd_t  cmd;
  h264sps_pkg::stat_t stat;

  h264sps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  h264sps_dp u_dp (
    .clk(clk), .rst(rst), .in_data(in_data), .cmd(cmd), .stat(stat),
    .out_data(out_data)
  );

endmodule

// ===== design/h264sps_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264sps_chk
// Port-level checks for the SPS field extractor, bound to the top level.
// ----------------------------------------------------------------------------
module h264sps_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input h264sps_pkg::in_t   in_data,
  input logic               out_valid,
  input logic               out_ready,
  input h264sps_pkg::out_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a byte occupies the bit-serial decoder, which keeps in_ready low after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("byte accepted back to back");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != h264sps_pkg::ST_OK |->
      out_data.pic_width == 16'd0 && out_data.sar_den == 16'd1 &&
      out_data.sar_num == 16'd0 && !out_data.timing_valid)
    else $error("failed parse with nonzero fields");

  a_timing_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.timing_valid && out_data.time_scale_out == 32'd0 |->
      out_data.frame_duration == 32'd0)
    else $error("zero time scale with nonzero duration");

endmodule

bind h264_sps_field_extractor h264sps_chk u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data)
);

// ===== test/h264_sps_field_extractor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_sps_field_extractor_test
// Feeds whole SPS payloads (well-formed, truncated, broken, noise) through the
// valid/ready input one byte per transaction, predicts each result with a
// bit-serial model of the parser and compares every field of every result.
// ----------------------------------------------------------------------------
module h264_sps_field_extractor_test;
  import h264sps_pkg::*;

  // Tracks the parser state byte by byte and holds the results it predicts.
  class sps_result_board;
    out_t        pending_results[$];
    int          errors;
    phase_t      ph;
    rd_mode_t    mode;
    bit [5:0]    zcnt, nleft;
    bit [31:0]   gval, lcnt, sar, hscale;
    bit [31:0]   kept_ticks, kept_scale, kept_dur;
    bit [7:0]    prof;
    bit [3:0]    lidx;
    bit [15:0]   last_next;
    longint      wacc, hacc;
    bit          fmbs, timing, rdy;
    bit [1:0]    st;
    bit [31:0]   aspect[17];

    function new();
      aspect = '{32'h0000_0001, {16'd1, 16'd1}, {16'd12, 16'd11}, {16'd10, 16'd11},
                 {16'd16, 16'd11}, {16'd40, 16'd33}, {16'd24, 16'd11},
                 {16'd20, 16'd11}, {16'd32, 16'd11}, {16'd80, 16'd33},
                 {16'd18, 16'd11}, {16'd15, 16'd11}, {16'd64, 16'd33},
                 {16'd160, 16'd99}, {16'd4, 16'd3}, {16'd3, 16'd2}, {16'd2, 16'd1}};
      clear_set();
      kept_ticks = 0;
      kept_scale = 0;
      kept_dur = 0;
    endfunction

    function void clear_set();
      zcnt = 0; gval = 0; nleft = 0; mode = RD_FIXED; prof = 0; lcnt = 0;
      lidx = 0; last_next = 16'h0808; wacc = 0; hacc = 0; fmbs = 0;
      sar = 32'd1; hscale = 0; st = ST_OK; timing = 0; rdy = 0; ph = PH_IDLE;
    endfunction

    function void want(phase_t p, int n);
      ph = p;
      zcnt = 0;
      gval = 0;
      nleft = n;
      mode = (n != 0) ? RD_FIXED : RD_PREFIX;
    endfunction

    function void done(bit [1:0] s);
      ph = PH_END;
      st = s;
      rdy = 1;
    endfunction

    function bit is_high(bit [7:0] p);
      return p == 100 || p == 110 || p == 122 || p == 244 || p == 44;
    endfunction

    function bit [31:0] se_of(bit [31:0] k);
      bit [32:0] mag;
      if (k == 0) return 0;
      mag = ({1'b0, k} + 33'd1) >> 1;
      return k[0] ? mag[31:0] : 32'd0 - mag[31:0];
    endfunction

    function void next_list();
      lidx = lidx + 1;
      if (lidx < 8) want(PH_LISTFLAG, 1);
      else want(PH_LOG2FN, 0);
    endfunction

    function void scale_run();
      bit [31:0] size;
      size = (lidx < 6) ? 16 : 64;
      while (lcnt < size) begin
        if (last_next[7:0] != 0) begin
          want(PH_DELTA, 0);
          return;
        end
        lcnt++;
      end
      next_list();
    endfunction

    function void got(bit [31:0] v);
      bit [7:0]  lst, nxt;
      bit [31:0] ticks;
      bit [63:0] q;
      case (ph)
        PH_PROFILE: begin
          prof = v[7:0];
          if (v == 66 || v == 77 || v == 88 || is_high(v[7:0])) want(PH_CONSTR, 8);
          else done(ST_BAD_PROF);
        end
        PH_CONSTR: want(PH_LEVEL, 8);
        PH_LEVEL: want(PH_SPSID, 0);
        PH_SPSID: if (is_high(prof)) want(PH_CHROMA, 0); else want(PH_LOG2FN, 0);
        PH_CHROMA: if (v == 3) want(PH_RESID, 1); else want(PH_BDL, 0);
        PH_RESID: want(PH_BDL, 0);
        PH_BDL: want(PH_BDC, 0);
        PH_BDC: want(PH_BYPASS, 1);
        PH_BYPASS: want(PH_SMPRES, 1);
        PH_SMPRES: begin
          if (v != 0) begin
            lidx = 0;
            want(PH_LISTFLAG, 1);
          end else want(PH_LOG2FN, 0);
        end
        PH_LISTFLAG: begin
          if (v != 0) begin
            lcnt = 0;
            last_next = 16'h0808;
            scale_run();
          end else next_list();
        end
        PH_DELTA: begin
          lst = last_next[15:8];
          nxt = lst + se_of(v);
          if (nxt != 0) lst = nxt;
          last_next = {lst, nxt};
          lcnt++;
          scale_run();
        end
        PH_LOG2FN: want(PH_POCTYPE, 0);
        PH_POCTYPE: begin
          if (v == 0) want(PH_POCLSB, 0);
          else if (v == 1) want(PH_DPOAZ, 1);
          else if (v == 2) want(PH_REFS, 0);
          else done(ST_BAD_POC);
        end
        PH_POCLSB: want(PH_REFS, 0);
        PH_DPOAZ: want(PH_OFFNR, 0);
        PH_OFFNR: want(PH_OFFTB, 0);
        PH_OFFTB: want(PH_NCYCLE, 0);
        PH_NCYCLE: begin
          lcnt = v;
          if (v != 0) want(PH_OFFREF, 0); else want(PH_REFS, 0);
        end
        PH_OFFREF: begin
          lcnt--;
          if (lcnt != 0) want(PH_OFFREF, 0); else want(PH_REFS, 0);
        end
        PH_REFS: want(PH_GAPS, 1);
        PH_GAPS: want(PH_WMB, 0);
        PH_WMB: begin
          wacc = (longint'(v) + 1) * 16;
          want(PH_HMB, 0);
        end
        PH_HMB: begin
          hacc = longint'(v) + 1;
          want(PH_FMO, 1);
        end
        PH_FMO: begin
          fmbs = v[0];
          hacc = hacc * (fmbs ? 16 : 32);
          if (fmbs) want(PH_D8, 1); else want(PH_MBAFF, 1);
        end
        PH_MBAFF: want(PH_D8, 1);
        PH_D8: want(PH_CROPF, 1);
        PH_CROPF: if (v != 0) want(PH_CL, 0); else want(PH_VUI, 1);
        PH_CL: begin wacc -= 2 * longint'(v); want(PH_CR, 0); end
        PH_CR: begin wacc -= 2 * longint'(v); want(PH_CT, 0); end
        PH_CT: begin hacc -= (fmbs ? 2 : 4) * longint'(v); want(PH_CB, 0); end
        PH_CB: begin hacc -= (fmbs ? 2 : 4) * longint'(v); want(PH_VUI, 1); end
        PH_VUI: if (v != 0) want(PH_ARPRES, 1); else done(ST_OK);
        PH_ARPRES: if (v != 0) want(PH_ARIDC, 8); else want(PH_OVS, 1);
        PH_ARIDC: begin
          if (v == ASPECT_EXT) want(PH_SARW, 16);
          else begin
            if (v < 17) sar = aspect[v];
            want(PH_OVS, 1);
          end
        end
        PH_SARW: begin sar = {v[15:0], sar[15:0]}; want(PH_SARH, 16); end
        PH_SARH: begin sar = {sar[31:16], v[15:0]}; want(PH_OVS, 1); end
        PH_OVS: if (v != 0) want(PH_OVSAPP, 1); else want(PH_VST, 1);
        PH_OVSAPP: want(PH_VST, 1);
        PH_VST: if (v != 0) want(PH_VFMT, 4); else want(PH_CHL, 1);
        PH_VFMT: want(PH_COLP, 1);
        PH_COLP: if (v != 0) want(PH_COLD, 24); else want(PH_CHL, 1);
        PH_COLD: want(PH_CHL, 1);
        PH_CHL: if (v != 0) want(PH_CHT, 0); else want(PH_TIM, 1);
        PH_CHT: want(PH_CHB, 0);
        PH_CHB: want(PH_TIM, 1);
        PH_TIM: if (v != 0) want(PH_NUT, 32); else done(ST_OK);
        PH_NUT: begin lcnt = v; want(PH_TS, 32); end
        PH_TS: begin hscale = v; want(PH_FIXED, 1); end
        PH_FIXED: begin
          if (v != 0) begin
            ticks = lcnt << 1;
            q = 0;
            if (hscale != 0) q = (64'd90000 * ticks) / hscale;
            kept_dur = (q > 64'hffff_ffff) ? 32'hffff_ffff : q[31:0];
            kept_ticks = ticks;
            kept_scale = hscale;
            timing = 1;
          end
          done(ST_OK);
        end
        default: ;
      endcase
    endfunction

    function void take_bit(bit b);
      if (ph == PH_IDLE || ph == PH_END) return;
      if (mode == RD_FIXED) begin
        gval = {gval[30:0], b};
        nleft--;
        if (nleft == 0) got(gval);
      end else if (mode == RD_PREFIX) begin
        if (!b) begin
          if (zcnt < 63) zcnt++;
        end else if (zcnt == 0) got(0);
        else begin
          gval = 1;
          nleft = zcnt;
          mode = RD_SUFFIX;
        end
      end else begin
        gval = {gval[30:0], b};
        nleft--;
        if (nleft == 0) got(gval - 1);
      end
    endfunction

    function bit [15:0] clamp16(longint v);
      if (v < 0) return 0;
      if (v > 65535) return 16'hffff;
      return v[15:0];
    endfunction

    function void note_byte(in_t d);
      out_t r;
      rdy = 0;
      if (d.first_byte) begin
        clear_set();
        want(PH_PROFILE, 8);
      end
      for (int k = 7; k >= 0; k--) take_bit(d.data_byte[k]);
      if (d.last_byte && ph != PH_IDLE && ph != PH_END) begin
        st = ST_TRUNC;
        rdy = 1;
      end
      if (d.last_byte) ph = PH_IDLE;
      if (!rdy) return;
      r.status = st;
      if (st == ST_OK) begin
        r.pic_width = clamp16(wacc);
        r.pic_height = clamp16(hacc);
        r.sar_num = sar[31:16];
        r.sar_den = sar[15:0];
        r.timing_valid = timing;
      end else begin
        r.pic_width = 0;
        r.pic_height = 0;
        r.sar_num = 0;
        r.sar_den = 1;
        r.timing_valid = 0;
      end
      r.tick_units = kept_ticks;
      r.time_scale_out = kept_scale;
      r.frame_duration = kept_dur;
      pending_results.push_back(r);
    endfunction

    function void report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endfunction

    function void check_result(out_t got_r);
      out_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %h", got_r));
        return;
      end
      e = pending_results.pop_front();
      if (got_r.status != e.status)
        report($sformatf("status %0d, want %0d", got_r.status, e.status));
      if (got_r.pic_width != e.pic_width)
        report($sformatf("pic_width %0d, want %0d", got_r.pic_width, e.pic_width));
      if (got_r.pic_height != e.pic_height)
        report($sformatf("pic_height %0d, want %0d", got_r.pic_height, e.pic_height));
      if (got_r.sar_num != e.sar_num)
        report($sformatf("sar_num %0d, want %0d", got_r.sar_num, e.sar_num));
      if (got_r.sar_den != e.sar_den)
        report($sformatf("sar_den %0d, want %0d", got_r.sar_den, e.sar_den));
      if (got_r.timing_valid != e.timing_valid)
        report($sformatf("timing_valid %0d, want %0d", got_r.timing_valid, e.timing_valid));
      if (got_r.tick_units != e.tick_units)
        report($sformatf("tick_units %h, want %h", got_r.tick_units, e.tick_units));
      if (got_r.time_scale_out != e.time_scale_out)
        report($sformatf("time_scale_out %h, want %h", got_r.time_scale_out,
                         e.time_scale_out));
      if (got_r.frame_duration != e.frame_duration)
        report($sformatf("frame_duration %h, want %h", got_r.frame_duration,
                         e.frame_duration));
    endfunction
  endclass

  localparam int FLAV_RANDOM = 0;
  localparam int FLAV_BAD_PROF = 1;
  localparam int FLAV_BAD_POC = 2;
  localparam int FLAV_ZERO_SCALE = 3;
  localparam int FLAV_SAT_DUR = 4;
  localparam int FLAV_LONG_CODE = 5;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;

  sps_result_board board = new();
  int    send_idle_pct, recv_stall_pct;
  int    bytes_sent;
  bit    drained = 1'b0;
  bit    sps_bits[$];

  h264_sps_field_extractor i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) board.note_byte(in_data);
    if (!rst && out_valid && out_ready) board.check_result(out_data);
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  initial begin
    #30ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_byte(bit [7:0] b, bit first, bit last);
    in_t d;
    d.data_byte = b;
    d.first_byte = first;
    d.last_byte = last;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic put_bits(bit [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) sps_bits.push_back(v[i]);
  endtask

  task automatic put_ue(bit [63:0] v);
    bit [63:0] x;
    int n;
    x = v + 1;
    n = 1;
    while (n < 64 && (x >> n) != 0) n++;
    put_bits(0, n - 1);
    put_bits(x, n);
  endtask

  task automatic put_se(int s);
    put_ue(s > 0 ? 2 * s - 1 : -2 * s);
  endtask

  // Mostly small values; now and then a large one to reach the clamps.
  function automatic bit [63:0] pick_ue(int small_max);
    if ($urandom_range(19) == 0) return $urandom_range(20000);
    return $urandom_range(small_max);
  endfunction

  task automatic compose_sps(int flavor);
    bit [7:0] prof, lst, nxt, aidc;
    bit fmbs;
    int poc, ncyc, dlt;
    bit [7:0] profs[8] = '{66, 77, 88, 100, 110, 122, 244, 44};
    sps_bits.delete();
    prof = profs[$urandom_range(7)];
    if (flavor == FLAV_BAD_PROF || $urandom_range(29) == 0) begin
      prof = $urandom_range(255);
      if (flavor == FLAV_BAD_PROF) prof = 8'd0;
    end
    put_bits(prof, 8);
    put_bits($urandom_range(255), 8);
    put_bits($urandom_range(255), 8);
    if (flavor == FLAV_LONG_CODE) begin
      put_bits(0, 70);                   // prefix past the zero-count limit
      put_bits(64'h1_2345_6789, 46);
    end else put_ue(pick_ue(31));
    if (prof == 100 || prof == 110 || prof == 122 || prof == 244 || prof == 44) begin
      if ($urandom_range(3) == 0) begin
        put_ue(3);
        put_bits($urandom_range(1), 1);
      end else put_ue($urandom_range(2));
      put_ue($urandom_range(6));
      put_ue($urandom_range(6));
      put_bits($urandom_range(1), 1);
      if ($urandom_range(2) == 0) begin
        put_bits(1, 1);
        for (int l = 0; l < 8; l++) begin
          if ($urandom_range(2) == 0) begin
            put_bits(1, 1);
            lst = 8;
            nxt = 8;
            for (int j = 0; j < (l < 6 ? 16 : 64); j++) begin
              if (nxt != 0) begin
                dlt = $urandom_range(16) - 8;
                if ($urandom_range(15) == 0) dlt = -int'(lst);
                if ($urandom_range(31) == 0) dlt = 127;
                put_se(dlt);
                nxt = lst + dlt;
                if (nxt != 0) lst = nxt;
              end
            end
          end else put_bits(0, 1);
        end
      end else put_bits(0, 1);
    end
    put_ue($urandom_range(12));
    poc = $urandom_range(2);
    if (flavor == FLAV_BAD_POC || $urandom_range(29) == 0) poc = 3 + $urandom_range(5);
    put_ue(poc);
    if (poc == 0) put_ue($urandom_range(12));
    else if (poc == 1) begin
      put_bits($urandom_range(1), 1);
      put_se($urandom_range(200) - 100);
      put_se($urandom_range(200) - 100);
      ncyc = $urandom_range(4);
      put_ue(ncyc);
      for (int i = 0; i < ncyc; i++) put_se($urandom_range(40) - 20);
    end
    put_ue($urandom_range(16));
    put_bits($urandom_range(1), 1);
    put_ue(pick_ue(130));
    put_ue(pick_ue(80));
    fmbs = $urandom_range(1);
    put_bits(fmbs, 1);
    if (!fmbs) put_bits($urandom_range(1), 1);
    put_bits($urandom_range(1), 1);
    if ($urandom_range(2) == 0) begin
      put_bits(1, 1);
      repeat (4) put_ue($urandom_range(9) == 0 ? $urandom_range(5000) : $urandom_range(8));
    end else put_bits(0, 1);
    if (flavor >= FLAV_ZERO_SCALE || $urandom_range(3) != 0) begin
      put_bits(1, 1);
      if ($urandom_range(3) != 0) begin
        put_bits(1, 1);
        case ($urandom_range(3))
          0: aidc = ASPECT_EXT;
          1: aidc = $urandom_range(255);
          default: aidc = $urandom_range(17);
        endcase
        put_bits(aidc, 8);
        if (aidc == ASPECT_EXT) begin
          put_bits($urandom_range(3) == 0 ? 0 : $urandom(), 16);
          put_bits($urandom_range(3) == 0 ? 0 : $urandom(), 16);
        end
      end else put_bits(0, 1);
      if ($urandom_range(1)) put_bits({1'b1, 1'($urandom_range(1))}, 2);
      else put_bits(0, 1);
      if ($urandom_range(1)) begin
        put_bits(1, 1);
        put_bits($urandom_range(15), 4);
        if ($urandom_range(1)) put_bits({1'b1, 24'($urandom())}, 25);
        else put_bits(0, 1);
      end else put_bits(0, 1);
      if ($urandom_range(1)) begin
        put_bits(1, 1);
        put_ue($urandom_range(5));
        put_ue($urandom_range(5));
      end else put_bits(0, 1);
      if (flavor >= FLAV_ZERO_SCALE || $urandom_range(4) != 0) begin
        put_bits(1, 1);
        case (flavor)
          FLAV_ZERO_SCALE: put_bits({32'($urandom()), 32'd0}, 64);
          FLAV_SAT_DUR: put_bits({32'hffff_ffff, 32'd1}, 64);
          default: begin
            put_bits($urandom_range(3) == 0 ? $urandom() : $urandom_range(3000), 32);
            put_bits($urandom_range(3) == 0 ? $urandom() : $urandom_range(120000), 32);
          end
        endcase
        put_bits(flavor >= FLAV_ZERO_SCALE ? 1 : $urandom_range(3) != 0, 1);
      end else put_bits(0, 1);
    end else put_bits(0, 1);
  endtask

  // Packs the composed bits and sends them; the tail may be cut, padded or
  // left without a closing byte.
  task automatic send_sps(int flavor, bit allow_cut);
    bit [7:0] bytes[$];
    bit [7:0] b;
    int n;
    bit close;
    compose_sps(flavor);
    while (sps_bits.size() % 8 != 0) sps_bits.push_back($urandom_range(1));
    for (int i = 0; i < sps_bits.size(); i += 8) begin
      for (int k = 0; k < 8; k++) b[7 - k] = sps_bits[i + k];
      bytes.push_back(b);
    end
    if (allow_cut && $urandom_range(9) == 0)
      bytes = bytes[0:$urandom_range(bytes.size() - 1)];
    else if ($urandom_range(4) == 0)
      repeat ($urandom_range(1, 2)) bytes.push_back($urandom_range(255));
    close = !allow_cut || $urandom_range(19) != 0;
    n = bytes.size();
    for (int i = 0; i < n; i++) send_byte(bytes[i], i == 0, close && i == n - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  initial begin
    int phase_pct[3][2] = '{'{6, 65}, '{65, 6}, '{0, 0}};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: idle strays, bad profile/POC, truncation, timing, long code
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_sps(FLAV_BAD_PROF, 1'b0);
    send_sps(FLAV_BAD_POC, 1'b0);
    send_byte(8'd100, 1'b1, 1'b0);
    send_byte(8'h5a, 1'b0, 1'b1);
    send_byte(8'd66, 1'b1, 1'b1);
    send_sps(FLAV_ZERO_SCALE, 1'b0);
    send_sps(FLAV_SAT_DUR, 1'b0);
    send_sps(FLAV_LONG_CODE, 1'b0);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      bytes_sent = 0;
      while (bytes_sent < 140) begin
        if ($urandom_range(19) == 0) send_byte($urandom_range(255), 1'b0, $urandom_range(1));
        case ($urandom_range(19))
          0: send_sps(FLAV_SAT_DUR, 1'b1);
          1: send_sps(FLAV_ZERO_SCALE, 1'b1);
          2: send_sps(FLAV_LONG_CODE, 1'b1);
          default: send_sps(FLAV_RANDOM, 1'b1);
        endcase
        if (p == 1 && bytes_sent > 70 && !drained) begin
          drain();
          drained = 1'b1;
        end
      end
    end

    drain();
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/h264sps_pkg.sv
design/h264sps_ctrl.sv
design/h264sps_dp.sv
design/h264_sps_field_extractor.sv
design/h264sps_chk.sv
test/h264_sps_field_extractor_test.sv
